@@ rtl/ddn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddn_pkg
// shared types, constants and helpers of the detection decode and nms core
// ----------------------------------------------------------------------------
package ddn_pkg;

    localparam logic [7:0] BOX_COLS       = 8'd4;
    localparam logic [7:0] OBJ_COL        = 8'd4;
    localparam logic [7:0] CLASS_START_V0 = 8'd5;
    localparam logic [7:0] CLASS_START_V1 = 8'd4;
    localparam logic [7:0] NO_CLASS       = 8'hFF;
    localparam logic signed [31:0] Q_ONE  = 32'sd65536;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [7:0] {
        CFG_MODEL_VARIANT     = 8'd0,
        CFG_CONF_THRESHOLD    = 8'd1,
        CFG_OVERLAP_THRESHOLD = 8'd2,
        CFG_X_SCALE           = 8'd3,
        CFG_Y_SCALE           = 8'd4
    } cfg_index_t;

    typedef struct packed {
        logic               valid;
        logic               kept;
        logic        [7:0]  cls;
        logic signed [31:0] score;
        logic signed [31:0] left;
        logic signed [31:0] top;
        logic signed [31:0] width;
        logic signed [31:0] height;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROTATE,
        OP_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     mark;
    } chain_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONF_WAIT,
        ST_CONF,
        ST_GEO_WAIT,
        ST_GEO_TAKE,
        ST_INSERT,
        ST_FRAME,
        ST_NMS_LOAD,
        ST_NMS_SCAN,
        ST_NMS_IOU,
        ST_NMS_DECIDE,
        ST_EMIT,
        ST_EMIT_EMPTY
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        begin
            hi = {{36{1'b0}}, S32_MAX};
            lo = {{36{1'b1}}, S32_MIN};
            if (v > hi)
                return S32_MAX;
            else if (v < lo)
                return S32_MIN;
            else
                return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/detection_decode_nms_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// detection_decode_nms_core
// streaming detector row decoder with per-class non-maximum suppression
// ----------------------------------------------------------------------------
// Elements of a row are taken one per cycle. At each row end the input
// stalls for the confidence step and again when the row is stored, for
// box scaling, which runs four products through one shared multiplier,
// and for the insert; it also stalls from frame end until results are out.
// Stored rows enter a chain of MAX_CANDIDATES cells already sorted by
// confidence. At frame end suppression rotates the chain once per
// candidate, testing overlap against kept boxes of the same class until
// one overlaps, then drains the chain while results are delivered and
// waits whenever the output stalls.
module detection_decode_nms_core #(
    parameter int MAX_CANDIDATES = 64,
    parameter int MAX_COLUMNS    = 128
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [31:0]  s_axis_tdata,   // value
    input  wire  [0:0]   s_axis_tuser,   // end_of_row
    input  wire          s_axis_tlast,   // end_of_frame
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [167:0] m_axis_tdata,   // class_index, score, left, top, width, height
    output logic [1:0]   m_axis_tuser,   // is_detection, overflowed
    output logic         m_axis_tlast,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [7:0]   cfg_index,
    input  wire  [31:0]  cfg_data
);
    import ddn_pkg::*;

    localparam int CW = $clog2(MAX_CANDIDATES + 1);
    localparam logic [CW-1:0] CAND_MAX = CW'(MAX_CANDIDATES);
    localparam logic [7:0]    COL_MAX  = 8'(MAX_COLUMNS);

    // configuration
    logic        variant_reg;
    logic [16:0] conf_thr_reg, ovl_thr_reg;
    logic [23:0] xs_reg, ys_reg;

    state_t state_reg, state_next;

    logic [7:0]         col_reg, col_next;
    logic signed [31:0] box_reg [4];
    logic signed [31:0] box_next [4];
    logic signed [31:0] obj_reg, obj_next, best_reg, best_next;
    logic [7:0]         bcls_reg, bcls_next;

    logic signed [31:0] cl_box_reg [4];
    logic signed [31:0] cl_box_next [4];
    logic signed [31:0] cl_obj_reg, cl_obj_next, cl_best_reg, cl_best_next;
    logic [7:0]         cl_cls_reg, cl_cls_next;
    logic               eof_reg, eof_next;

    logic signed [33:0] mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic signed [67:0] prod_reg;

    logic signed [31:0] conf_reg, conf_next;
    logic [1:0]         gidx_reg, gidx_next;
    logic signed [31:0] geo_reg [4];
    logic signed [31:0] geo_next [4];

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next, rot_reg, rot_next, nk_reg, nk_next;
    logic [CW-1:0] emitted_reg, emitted_next;
    logic          drop_reg, drop_next;
    entry_t        cur_reg, cur_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_det_reg, out_det_next;
    logic               out_last_reg, out_last_next;
    logic               out_ovf_reg, out_ovf_next;
    entry_t             out_reg, out_next;

    chain_ctl_t ctl;
    entry_t     new_entry;
    entry_t     chain_q [MAX_CANDIDATES];
    logic       ins_q [MAX_CANDIDATES];
    entry_t     head;

    logic iou_start, iou_done, iou_over;

    // comb helpers
    logic signed [31:0] v;
    logic [7:0]         start_col, kcol;
    logic               out_free;
    logic signed [31:0] conf_c;
    logic               pass_c;
    logic signed [67:0] shifted;
    logic signed [33:0] ga [4];

    assign head          = chain_q[0];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_det_reg};
    assign m_axis_tdata  = {out_reg.height, out_reg.width, out_reg.top, out_reg.left,
                            out_reg.score, out_reg.cls};

    // candidate chain
    genvar g;
    generate
        for (g = 0; g < MAX_CANDIDATES; g++)
        begin : g_cell
            entry_t pe, ne;
            logic   pi;
            if (g == 0)
            begin : g_first
                assign pe = '0;
                assign pi = 1'b0;
            end
            else
            begin : g_mid
                assign pe = chain_q[g-1];
                assign pi = ins_q[g-1];
            end
            if (g == MAX_CANDIDATES - 1)
            begin : g_end
                assign ne = '0;
            end
            else
            begin : g_inner
                assign ne = chain_q[g+1];
            end
            ddn_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .new_entry  (new_entry),
                .prev_entry (pe),
                .prev_ins   (pi),
                .next_entry (ne),
                .head_entry (head),
                .is_tail    (count_reg == CW'(g + 1)),
                .entry      (chain_q[g]),
                .ins        (ins_q[g])
            );
        end
    endgenerate

    ddn_iou u_iou (
        .clk   (clk),
        .rst_n (rst_n),
        .start (iou_start),
        .a     (cur_reg),
        .b     (head),
        .thr   (ovl_thr_reg),
        .done  (iou_done),
        .over  (iou_over)
    );

    // scaling operands: width, height, left, top
    assign ga[0] = {{2{cl_box_reg[2][31]}}, cl_box_reg[2]};
    assign ga[1] = {{2{cl_box_reg[3][31]}}, cl_box_reg[3]};
    assign ga[2] = {cl_box_reg[0][31], cl_box_reg[0], 1'b0} - ga[0];
    assign ga[3] = {cl_box_reg[1][31], cl_box_reg[1], 1'b0} - ga[1];

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        box_next       = box_reg;
        obj_next       = obj_reg;
        best_next      = best_reg;
        bcls_next      = bcls_reg;
        cl_box_next    = cl_box_reg;
        cl_obj_next    = cl_obj_reg;
        cl_best_next   = cl_best_reg;
        cl_cls_next    = cl_cls_reg;
        eof_next       = eof_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        conf_next      = conf_reg;
        gidx_next      = gidx_reg;
        geo_next       = geo_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        rot_next       = rot_reg;
        nk_next        = nk_reg;
        emitted_next   = emitted_reg;
        drop_next      = drop_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_det_next   = out_det_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_next       = out_reg;
        ctl.op         = OP_HOLD;
        ctl.mark       = 1'b0;
        iou_start      = 1'b0;

        v         = s_axis_tdata;
        start_col = variant_reg ? CLASS_START_V1 : CLASS_START_V0;
        kcol      = col_reg - start_col;
        out_free  = !out_valid_reg || m_axis_tready;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (!cl_cls_reg[7])
            conf_c = variant_reg ? cl_best_reg : sat32(prod_reg >>> 16);
        else
            conf_c = variant_reg ? Q_ONE : cl_obj_reg;
        pass_c  = $signed({conf_c[31], conf_c}) >= $signed({16'd0, conf_thr_reg});
        shifted = gidx_reg[1] ? (prod_reg >>> 17) : (prod_reg >>> 16);

        new_entry        = '0;
        new_entry.valid  = 1'b1;
        new_entry.cls    = cl_cls_reg;
        new_entry.score  = conf_reg;
        new_entry.width  = geo_reg[0];
        new_entry.height = geo_reg[1];
        new_entry.left   = geo_reg[2];
        new_entry.top    = geo_reg[3];

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (col_reg < COL_MAX)
                    begin
                        if (col_reg < BOX_COLS)
                            box_next[col_reg[1:0]] = v;
                        else if (!variant_reg && col_reg == OBJ_COL)
                            obj_next = v;
                        else if (col_reg >= start_col && !kcol[7]
                                 && (bcls_reg[7] || v > best_reg))
                        begin
                            best_next = v;
                            bcls_next = kcol;
                        end
                    end
                    if (col_reg != 8'hFF)
                        col_next = col_reg + 8'd1;
                    if (s_axis_tuser[0] || s_axis_tlast)
                    begin
                        cl_box_next  = box_next;
                        cl_obj_next  = obj_next;
                        cl_best_next = best_next;
                        cl_cls_next  = bcls_next;
                        mul_a_next   = {{2{obj_next[31]}}, obj_next};
                        mul_b_next   = {{2{best_next[31]}}, best_next};
                        eof_next     = s_axis_tlast;
                        col_next     = '0;
                        for (int k = 0; k < 4; k++)
                            box_next[k] = '0;
                        obj_next     = '0;
                        best_next    = S32_MIN;
                        bcls_next    = NO_CLASS;
                        state_next   = ST_CONF_WAIT;
                    end
                end
            end
            ST_CONF_WAIT: state_next = ST_CONF;
            ST_CONF:
            begin
                conf_next = conf_c;
                if (pass_c && count_reg < CAND_MAX)
                begin
                    mul_a_next = ga[0];
                    mul_b_next = {10'd0, xs_reg};
                    gidx_next  = 2'd0;
                    state_next = ST_GEO_WAIT;
                end
                else
                begin
                    if (pass_c)
                        ovf_next = 1'b1;
                    state_next = eof_reg ? ST_FRAME : ST_IDLE;
                end
            end
            ST_GEO_WAIT: state_next = ST_GEO_TAKE;
            ST_GEO_TAKE:
            begin
                geo_next[gidx_reg] = sat32(shifted);
                if (gidx_reg == 2'd3)
                    state_next = ST_INSERT;
                else
                begin
                    gidx_next  = gidx_reg + 2'd1;
                    mul_a_next = ga[gidx_next];
                    mul_b_next = {10'd0, gidx_next[0] ? ys_reg : xs_reg};
                    state_next = ST_GEO_WAIT;
                end
            end
            ST_INSERT:
            begin
                ctl.op     = OP_INSERT;
                count_next = count_reg + 1'b1;
                state_next = eof_reg ? ST_FRAME : ST_IDLE;
            end
            ST_FRAME:
            begin
                i_next       = '0;
                nk_next      = '0;
                emitted_next = '0;
                state_next   = (count_reg == '0) ? ST_EMIT_EMPTY : ST_NMS_LOAD;
            end
            ST_NMS_LOAD:
            begin
                cur_next   = head;
                drop_next  = 1'b0;
                rot_next   = '0;
                state_next = ST_NMS_SCAN;
            end
            ST_NMS_SCAN:
            begin
                if (rot_reg == count_reg)
                    state_next = ST_NMS_DECIDE;
                else if (head.kept && head.cls == cur_reg.cls && !drop_reg)
                begin
                    iou_start  = 1'b1;
                    state_next = ST_NMS_IOU;
                end
                else
                begin
                    ctl.op   = OP_ROTATE;
                    rot_next = rot_reg + 1'b1;
                end
            end
            ST_NMS_IOU:
            begin
                if (iou_done)
                begin
                    drop_next  = drop_reg | iou_over;
                    ctl.op     = OP_ROTATE;
                    rot_next   = rot_reg + 1'b1;
                    state_next = ST_NMS_SCAN;
                end
            end
            ST_NMS_DECIDE:
            begin
                ctl.op   = OP_ROTATE;
                ctl.mark = !drop_reg;
                if (!drop_reg)
                    nk_next = nk_reg + 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg == count_reg - 1'b1)
                begin
                    rot_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_NMS_LOAD;
            end
            ST_EMIT:
            begin
                if (rot_reg == count_reg)
                begin
                    if (nk_reg == '0)
                        state_next = ST_EMIT_EMPTY;
                    else
                    begin
                        count_next = '0;
                        nk_next    = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
                else if (out_free)
                begin
                    ctl.op   = OP_POP;
                    rot_next = rot_reg + 1'b1;
                    if (head.kept)
                    begin
                        out_valid_next = 1'b1;
                        out_det_next   = 1'b1;
                        out_next       = head;
                        out_last_next  = (CW'(emitted_reg + 1'b1) == nk_reg);
                        out_ovf_next   = ovf_reg;
                        emitted_next   = emitted_reg + 1'b1;
                    end
                end
            end
            ST_EMIT_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_det_next   = 1'b0;
                    out_next       = '0;
                    out_last_next  = 1'b1;
                    out_ovf_next   = ovf_reg;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg   <= 1'b0;
            conf_thr_reg  <= 17'd16384;
            ovl_thr_reg   <= 17'd29491;
            xs_reg        <= 24'd65536;
            ys_reg        <= 24'd65536;
            col_reg       <= '0;
            for (int k = 0; k < 4; k++)
                box_reg[k] <= '0;
            obj_reg       <= '0;
            best_reg      <= S32_MIN;
            bcls_reg      <= NO_CLASS;
            eof_reg       <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            rot_reg       <= '0;
            nk_reg        <= '0;
            emitted_reg   <= '0;
            drop_reg      <= 1'b0;
            gidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MODEL_VARIANT:     variant_reg  <= cfg_data[0];
                    CFG_CONF_THRESHOLD:    conf_thr_reg <= cfg_data[16:0];
                    CFG_OVERLAP_THRESHOLD: ovl_thr_reg  <= cfg_data[16:0];
                    CFG_X_SCALE:           xs_reg       <= cfg_data[23:0];
                    CFG_Y_SCALE:           ys_reg       <= cfg_data[23:0];
                    default: ;
                endcase
            end
            col_reg       <= col_next;
            box_reg       <= box_next;
            obj_reg       <= obj_next;
            best_reg      <= best_next;
            bcls_reg      <= bcls_next;
            eof_reg       <= eof_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            rot_reg       <= rot_next;
            nk_reg        <= nk_next;
            emitted_reg   <= emitted_next;
            drop_reg      <= drop_next;
            gidx_reg      <= gidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cl_box_reg   <= cl_box_next;
        cl_obj_reg   <= cl_obj_next;
        cl_best_reg  <= cl_best_next;
        cl_cls_reg   <= cl_cls_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        prod_reg     <= mul_a_reg * mul_b_reg;
        conf_reg     <= conf_next;
        geo_reg      <= geo_next;
        cur_reg      <= cur_next;
        out_det_reg  <= out_det_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
        out_reg      <= out_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAND_MAX)
        else $error("candidate count beyond chain length");

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nk_reg <= count_reg)
        else $error("more kept boxes than candidates");

    a_iou_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NMS_IOU) |-> (head.kept && head.cls == cur_reg.cls))
        else $error("overlap test against a box that is not a kept peer");

endmodule
`default_nettype wire

@@ rtl/ddn_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddn_cell
// one slot of the candidate chain: sorted insert, rotate and pop
// ----------------------------------------------------------------------------
module ddn_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ddn_pkg::chain_ctl_t ctl,
    input  ddn_pkg::entry_t     new_entry,
    input  ddn_pkg::entry_t     prev_entry,
    input  wire                 prev_ins,
    input  ddn_pkg::entry_t     next_entry,
    input  ddn_pkg::entry_t     head_entry,
    input  wire                 is_tail,
    output ddn_pkg::entry_t     entry,
    output logic                ins
);
    import ddn_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    entry_t wrap;

    assign entry = entry_reg;
    // new item goes after every stored item of equal or higher score
    assign ins = !entry_reg.valid || (entry_reg.score < new_entry.score);

    always_comb
    begin
        wrap       = head_entry;
        wrap.kept  = head_entry.kept | ctl.mark;
        entry_next = entry_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (ins)
                    entry_next = prev_ins ? prev_entry : new_entry;
            end
            OP_ROTATE: entry_next = is_tail ? wrap : next_entry;
            OP_POP:    entry_next = next_entry;
            default:   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

@@ rtl/ddn_iou.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddn_iou
// multi-cycle overlap test: inter * 2^16 > threshold * union, one multiplier
// ----------------------------------------------------------------------------
module ddn_iou (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    input  ddn_pkg::entry_t  a,
    input  ddn_pkg::entry_t  b,
    input  wire       [16:0] thr,
    output logic             done,
    output logic             over
);
    import ddn_pkg::*;

    logic signed [32:0] ra, rb, ba, bb;
    logic signed [32:0] la, lb, ta, tb;
    logic signed [33:0] ix, iy;

    logic               busy_reg;
    logic        [2:0]  step_reg;
    logic               hit_reg;
    logic signed [33:0] ix_reg, iy_reg, wa_reg, ha_reg, wb_reg, hb_reg;
    logic signed [67:0] p_reg;
    logic        [63:0] inter_reg;
    logic        [63:0] uni_reg;
    logic        [48:0] rlo_reg;
    logic        [16:0] thr_reg;

    logic signed [33:0] op_a, op_b;
    logic        [80:0] lhs, rhs;

    always_comb
    begin
        la = {a.left[31], a.left};
        lb = {b.left[31], b.left};
        ta = {a.top[31], a.top};
        tb = {b.top[31], b.top};
        ra = la + {a.width[31], a.width};
        rb = lb + {b.width[31], b.width};
        ba = ta + {a.height[31], a.height};
        bb = tb + {b.height[31], b.height};
        ix = {(ra < rb) ? ra[32] : rb[32], (ra < rb) ? ra : rb}
           - {(la > lb) ? la[32] : lb[32], (la > lb) ? la : lb};
        iy = {(ba < bb) ? ba[32] : bb[32], (ba < bb) ? ba : bb}
           - {(ta > tb) ? ta[32] : tb[32], (ta > tb) ? ta : tb};
    end

    always_comb
    begin
        case (step_reg)
            3'd1:
            begin
                op_a = wa_reg;
                op_b = ha_reg;
            end
            3'd2:
            begin
                op_a = wb_reg;
                op_b = hb_reg;
            end
            3'd4:
            begin
                op_a = {2'b00, uni_reg[31:0]};
                op_b = {17'd0, thr_reg};
            end
            3'd5:
            begin
                op_a = {2'b00, uni_reg[63:32]};
                op_b = {17'd0, thr_reg};
            end
            default:
            begin
                op_a = ix_reg;
                op_b = iy_reg;
            end
        endcase
    end

    assign lhs  = {1'b0, inter_reg, 16'd0};
    assign rhs  = {p_reg[48:0], 32'd0} + {32'd0, rlo_reg};
    assign done = busy_reg && (step_reg == 3'd6);
    assign over = hit_reg && (lhs > rhs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == 3'd6)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hit_reg <= (ix > 34'sd0) && (iy > 34'sd0);
            ix_reg  <= ix;
            iy_reg  <= iy;
            wa_reg  <= {{2{a.width[31]}}, a.width};
            ha_reg  <= {{2{a.height[31]}}, a.height};
            wb_reg  <= {{2{b.width[31]}}, b.width};
            hb_reg  <= {{2{b.height[31]}}, b.height};
            thr_reg <= thr;
        end
        else if (busy_reg)
        begin
            p_reg <= op_a * op_b;
            case (step_reg)
                3'd1: inter_reg <= p_reg[63:0];
                3'd2: uni_reg   <= p_reg[63:0] - inter_reg;
                3'd3: uni_reg   <= uni_reg + p_reg[63:0];
                3'd5: rlo_reg   <= p_reg[48:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire
